// ----- hdl/sbet_pkg.sv -----
package sbet_pkg;

   localparam int COORD_BITS_DEF     = 32;
   localparam int TIME_FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH        = 2;

   // normal component codes, two's complement
   localparam logic [1:0] NORM_ZERO = 2'b00;
   localparam logic [1:0] NORM_POS  = 2'b01;
   localparam logic [1:0] NORM_NEG  = 2'b11;

   typedef struct packed {
      logic vzero;    // no motion on this axis
      logic ov;       // axis overlaps strictly
      logic in_neg;   // entry time negative
      logic out_neg;  // exit time negative
      logic gin_neg;  // entry gap negative, picks the normal sign
   } axis_flags_type;

endpackage

// ----- hdl/swept_box_entry_time.sv -----
// Swept 2D box test: one moving box with its displacement against one still box
// per item, giving hit, the entry time as a fraction of the sweep and the contact
// normal. Takes one item every cycle while the result is not stalled; the path
// runs through the input register, one queue entry, a restoring divider that
// makes one quotient bit per stage for each of the four axis times, and the
// output register. A stalled result holds the back end; the front and its queue
// keep taking items until full.
module swept_box_entry_time #(
   parameter int COORD_BITS     = sbet_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = sbet_pkg::TIME_FRAC_BITS_DEF,
   parameter int REQ_DW = ((10 * COORD_BITS + 7) / 8) * 8,
   parameter int RSP_DW = ((TIME_FRAC_BITS + 5 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // mover_min_x, mover_min_y, mover_max_x, mover_max_y, target_min_x,
   // target_min_y, target_max_x, target_max_y, velocity_x, velocity_y
   input  logic [REQ_DW-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // hit, entry_time, normal_x, normal_y
   output logic [RSP_DW-1:0] rsp_tdata
);

   localparam int MW = COORD_BITS + 1;
   localparam int FW = $bits(sbet_pkg::axis_flags_type);
   localparam int QDW = 6 * MW + 2 * FW;

   logic f_valid, f_ready;
   logic [1:0][MW-1:0] f_gin, f_gout, f_vel;
   sbet_pkg::axis_flags_type [1:0] f_flags;
   logic b_valid, b_ready;
   logic [1:0][MW-1:0] b_gin, b_gout, b_vel;
   sbet_pkg::axis_flags_type [1:0] b_flags;
   logic [QDW-1:0] q_push, q_pop;
   logic hit;
   logic [TIME_FRAC_BITS-1:0] entry_time;
   logic [1:0] normal_x, normal_y;

   sbet_front #(.CW(COORD_BITS), .DW(REQ_DW), .MW(MW)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .out_valid(f_valid), .out_ready(f_ready),
      .gin_mag(f_gin), .gout_mag(f_gout), .vel_mag(f_vel), .flags(f_flags)
   );

   assign q_push = {f_flags, f_vel, f_gout, f_gin};

   sbet_queue #(.WIDTH(QDW), .DEPTH(sbet_pkg::QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(q_push),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(q_pop)
   );

   assign {b_flags, b_vel, b_gout, b_gin} = q_pop;

   sbet_back #(.MW(MW), .T(TIME_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_ready(b_ready),
      .gin_mag(b_gin), .gout_mag(b_gout), .vel_mag(b_vel), .flags(b_flags),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .hit(hit), .entry_time(entry_time), .normal_x(normal_x), .normal_y(normal_y)
   );

   assign rsp_tdata = RSP_DW'({normal_y, normal_x, entry_time, hit});

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !hit |-> entry_time == '0 && normal_x == sbet_pkg::NORM_ZERO
         && normal_y == sbet_pkg::NORM_ZERO)
      else $error("miss carries a nonzero time or normal");

   a_one_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit |-> (normal_x != sbet_pkg::NORM_ZERO) != (normal_y != sbet_pkg::NORM_ZERO))
      else $error("hit without exactly one normal axis");

   a_hit_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit |-> entry_time != '0)
      else $error("hit with zero entry time");

endmodule

// ----- hdl/sbet_front.sv -----
module sbet_front #(
   parameter int CW = sbet_pkg::COORD_BITS_DEF,
   parameter int DW = ((10 * CW + 7) / 8) * 8,
   parameter int MW = CW + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [DW-1:0]                   req_tdata,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [1:0][MW-1:0]              gin_mag,
   output logic [1:0][MW-1:0]              gout_mag,
   output logic [1:0][MW-1:0]              vel_mag,
   output sbet_pkg::axis_flags_type [1:0]  flags
);

   logic vld_ff, vld_in;
   logic [1:0][MW-1:0] gin_mag_ff, gout_mag_ff, vel_mag_ff;
   sbet_pkg::axis_flags_type [1:0] flags_ff;
   logic take;

   assign req_tready = !vld_ff || out_ready;
   assign take       = req_tvalid && req_tready;
   assign vld_in     = take || (vld_ff && !out_ready);

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic signed [CW-1:0] mmin, mmax, tmin, tmax, vel;
      logic signed [MW-1:0] gpos, gneg, gin, gout, vel_x;
      logic vpos;

      assign mmin = req_tdata[a * CW +: CW];
      assign mmax = req_tdata[(2 + a) * CW +: CW];
      assign tmin = req_tdata[(4 + a) * CW +: CW];
      assign tmax = req_tdata[(6 + a) * CW +: CW];
      assign vel  = req_tdata[(8 + a) * CW +: CW];

      assign gpos  = MW'(tmin) - MW'(mmax);
      assign gneg  = MW'(tmax) - MW'(mmin);
      assign vpos  = !vel[CW-1] && (vel != '0);
      assign gin   = vpos ? gpos : gneg;
      assign gout  = vpos ? gneg : gpos;
      assign vel_x = MW'(vel);

      always_ff @(posedge clock) begin
         if (take) begin
            gin_mag_ff[a]       <= gin[MW-1] ? -gin : gin;
            gout_mag_ff[a]      <= gout[MW-1] ? -gout : gout;
            vel_mag_ff[a]       <= vel_x[MW-1] ? -vel_x : vel_x;
            flags_ff[a].vzero   <= (vel == '0);
            flags_ff[a].ov      <= (mmin < tmax) && (mmax > tmin);
            flags_ff[a].in_neg  <= gin[MW-1] ^ vel[CW-1];
            flags_ff[a].out_neg <= gout[MW-1] ^ vel[CW-1];
            flags_ff[a].gin_neg <= gin[MW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff;
   assign gin_mag   = gin_mag_ff;
   assign gout_mag  = gout_mag_ff;
   assign vel_mag   = vel_mag_ff;
   assign flags     = flags_ff;

endmodule

// ----- hdl/sbet_queue.sv -----
module sbet_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sbet_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNTW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/sbet_div.sv -----
module sbet_div #(
   parameter int MW = sbet_pkg::COORD_BITS_DEF + 1,
   parameter int T  = sbet_pkg::TIME_FRAC_BITS_DEF,
   parameter int QW = T + 2
) (
   input  logic          clock,
   input  logic          en,
   input  logic [MW-1:0] g,
   input  logic [MW-1:0] v,
   output logic [QW-1:0] q,
   output logic          sat
);

   localparam int RW = MW + T + 2;

   // restoring divide, one quotient bit per stage, MSB first
   logic [RW-1:0] rem_ff [QW];
   logic [MW-1:0] v_ff   [QW];
   logic [QW-1:0] q_ff   [QW+1];
   logic          sat_ff [QW+1];
   logic [RW-1:0] dvs [QW];
   logic          ge  [QW];

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         dvs[s] = RW'(v_ff[s]) << (QW - 1 - s);
         ge[s]  = rem_ff[s] >= dvs[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(g) << T;
         v_ff[0]   <= v;
         q_ff[0]   <= '0;
         sat_ff[0] <= {2'b00, g} >= {v, 2'b00};
         for (int s = 0; s < QW; s++) begin
            if (s < QW - 1) begin
               rem_ff[s+1] <= ge[s] ? rem_ff[s] - dvs[s] : rem_ff[s];
               v_ff[s+1]   <= v_ff[s];
            end
            q_ff[s+1]   <= {q_ff[s][QW-2:0], ge[s]};
            sat_ff[s+1] <= sat_ff[s];
         end
      end
   end

   assign q   = q_ff[QW];
   assign sat = sat_ff[QW];

endmodule

// ----- hdl/sbet_back.sv -----
module sbet_back #(
   parameter int MW = sbet_pkg::COORD_BITS_DEF + 1,
   parameter int T  = sbet_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [1:0][MW-1:0]              gin_mag,
   input  logic [1:0][MW-1:0]              gout_mag,
   input  logic [1:0][MW-1:0]              vel_mag,
   input  sbet_pkg::axis_flags_type [1:0]  flags,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            hit,
   output logic [T-1:0]                    entry_time,
   output logic [1:0]                      normal_x,
   output logic [1:0]                      normal_y
);

   localparam int QW = T + 2;
   localparam int TW = T + 4;
   localparam int L  = QW + 1;
   localparam logic signed [TW-1:0] LIM = TW'(1) << (T + 2);
   localparam logic signed [TW-1:0] ONE = TW'(1) << T;

   logic en;
   logic vld_ff [L];
   sbet_pkg::axis_flags_type [1:0] sb_ff [L];
   logic out_vld_ff, out_vld_in;
   logic hit_ff;
   logic [T-1:0] et_ff;
   logic [1:0] nx_ff, ny_ff;

   logic [QW-1:0] q_in [2], q_out [2];
   logic sat_in [2], sat_out [2];
   logic signed [TW-1:0] tin [2], tout [2];
   logic signed [TW-1:0] entry, leave;
   logic hit_c;

   assign en         = !out_vld_ff || out_ready;
   assign in_ready   = en;
   assign out_vld_in = en ? vld_ff[L-1] : out_vld_ff;

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [TW-1:0] min_mag, mout_mag;

      sbet_div #(.MW(MW), .T(T)) u_div_in (
         .clock(clock), .en(en), .g(gin_mag[a]), .v(vel_mag[a]),
         .q(q_in[a]), .sat(sat_in[a])
      );
      sbet_div #(.MW(MW), .T(T)) u_div_out (
         .clock(clock), .en(en), .g(gout_mag[a]), .v(vel_mag[a]),
         .q(q_out[a]), .sat(sat_out[a])
      );

      assign min_mag  = sat_in[a] ? LIM : TW'(q_in[a]);
      assign mout_mag = sat_out[a] ? LIM : TW'(q_out[a]);

      always_comb begin
         if (sb_ff[L-1][a].vzero) begin
            tin[a]  = sb_ff[L-1][a].ov ? -LIM : LIM;
            tout[a] = sb_ff[L-1][a].ov ? LIM : -LIM;
         end else begin
            tin[a]  = sb_ff[L-1][a].in_neg ? -min_mag : min_mag;
            tout[a] = sb_ff[L-1][a].out_neg ? -mout_mag : mout_mag;
         end
      end
   end

   assign entry = (tin[0] > tin[1]) ? tin[0] : tin[1];
   assign leave = (tout[0] < tout[1]) ? tout[0] : tout[1];
   assign hit_c = (entry > 0) && (entry < ONE) && (leave > 0) && (entry <= leave);

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= flags;
         for (int s = 1; s < L; s++) begin
            sb_ff[s] <= sb_ff[s-1];
         end
         hit_ff <= hit_c;
         et_ff  <= hit_c ? entry[T-1:0] : '0;
         nx_ff  <= sbet_pkg::NORM_ZERO;
         ny_ff  <= sbet_pkg::NORM_ZERO;
         if (hit_c) begin
            // ties go to the x axis
            if (tin[0] < tin[1]) begin
               ny_ff <= sb_ff[L-1][1].gin_neg ? sbet_pkg::NORM_POS : sbet_pkg::NORM_NEG;
            end else begin
               nx_ff <= sb_ff[L-1][0].gin_neg ? sbet_pkg::NORM_POS : sbet_pkg::NORM_NEG;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < L; s++) begin
            vld_ff[s] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff[0] <= in_valid;
            for (int s = 1; s < L; s++) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
         out_vld_ff <= out_vld_in;
      end
   end

   assign out_valid  = out_vld_ff;
   assign hit        = hit_ff;
   assign entry_time = et_ff;
   assign normal_x   = nx_ff;
   assign normal_y   = ny_ff;

endmodule
